>>> sv/grc_pkg.sv
// Package for the grid ray-cast column block: shared types, codes, constants
// and the quarter-wave sine function.
// No dependencies.
package grc_pkg;

  localparam int MAP_SIZE_DEF  = 32;
  localparam int MAX_STEPS_DEF = 40;

  localparam int DIV_DW = 32;
  localparam int DIV_VW = 16;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_CAST  = 1'b1;

  localparam logic [2:0] REG_POS_X    = 3'd0;
  localparam logic [2:0] REG_POS_Y    = 3'd1;
  localparam logic [2:0] REG_VIEW     = 3'd2;
  localparam logic [2:0] REG_FOV      = 3'd3;
  localparam logic [2:0] REG_VP_W     = 3'd4;
  localparam logic [2:0] REG_VP_H     = 3'd5;
  localparam logic [2:0] REG_HORIZON  = 3'd6;

  localparam logic [1:0] DIV_ANGLE = 2'd0;
  localparam logic [1:0] DIV_DDX   = 2'd1;
  localparam logic [1:0] DIV_DDY   = 2'd2;
  localparam logic [1:0] DIV_LINE  = 2'd3;

  localparam logic [7:0] BASE_R_EW = 8'd100;
  localparam logic [7:0] BASE_G_EW = 8'd140;
  localparam logic [7:0] BASE_B_EW = 8'd60;
  localparam logic [7:0] BASE_R_NS = 8'd130;
  localparam logic [7:0] BASE_G_NS = 8'd180;
  localparam logic [7:0] BASE_B_NS = 8'd80;
  localparam logic [7:0] FOG_GREY  = 8'd80;
  localparam logic [11:0] FOG_LIMIT = 12'd2048;

  typedef struct packed {
    logic [15:0]       pos_x;
    logic [15:0]       pos_y;
    logic [15:0]       view_angle;
    logic [14:0]       fov;
    logic [8:0]        vp_w;
    logic [7:0]        vp_h;
    logic signed [9:0] horizon;
  } grc_cfg_t;

  typedef struct packed {
    logic       clear;
    logic       write_cell;
    logic       load_item;
    logic       div_start;
    logic [1:0] div_op;
    logic       ang_ld;
    logic       sine_ld;
    logic       ddx_ld;
    logic       ddy_ld;
    logic       init_ld;
    logic       step;
    logic       dist_ld;
    logic       out_ld;
  } grc_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic cast_ok;
    logic div_done;
    logic walk_stop;
  } grc_sts_t;

  function automatic logic [14:0] sine_tab(input logic [4:0] i);
    logic [14:0] v;
    unique case (i)
      5'd0:  v = 15'd0;
      5'd1:  v = 15'd1606;
      5'd2:  v = 15'd3196;
      5'd3:  v = 15'd4756;
      5'd4:  v = 15'd6270;
      5'd5:  v = 15'd7723;
      5'd6:  v = 15'd9102;
      5'd7:  v = 15'd10394;
      5'd8:  v = 15'd11585;
      5'd9:  v = 15'd12665;
      5'd10: v = 15'd13623;
      5'd11: v = 15'd14449;
      5'd12: v = 15'd15137;
      5'd13: v = 15'd15679;
      5'd14: v = 15'd16069;
      5'd15: v = 15'd16305;
      default: v = 15'd16384;
    endcase
    return v;
  endfunction

  // Interpolated quarter wave; u runs from 0 to 16384.
  function automatic logic [14:0] quarter_sine(input logic [14:0] u);
    logic [4:0]  i;
    logic [14:0] lo;
    logic [14:0] hi;
    logic [24:0] prod;
    i    = u[14:10];
    lo   = sine_tab(i);
    hi   = sine_tab(i + 5'd1);
    prod = 25'(hi - lo) * 25'(u[9:0]);
    if (i >= 5'd16) begin
      return 15'd16384;
    end
    return lo + 15'(prod >> 10);
  endfunction

  function automatic logic signed [15:0] bin_sine(input logic [15:0] a);
    logic [14:0] m;
    m = a[14] ? quarter_sine(15'd16384 - {1'b0, a[13:0]}) : quarter_sine({1'b0, a[13:0]});
    return a[15] ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

endpackage

>>> sv/grc_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on grc_pkg for its widths.
module grc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [grc_pkg::DIV_DW-1:0]    dividend,
  input  logic [grc_pkg::DIV_VW-1:0]    divisor,
  output logic                          done,
  output logic [grc_pkg::DIV_DW-1:0]    quotient
);

  localparam int DW = grc_pkg::DIV_DW;
  localparam int VW = grc_pkg::DIV_VW;
  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [VW:0]   rem_sh;
  logic          fits;
  logic [VW:0]   rem_sub;

  assign rem_sh  = {rem, quotient[DW-1]};
  assign fits    = rem_sh >= {1'b0, dvs};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CW'(DW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
      quotient <= {quotient[DW-2:0], fits};
    end
  end

endmodule

>>> sv/grc_dp.sv
// Datapath: wall map memory, angle and sine stage, DDA walk registers,
// span and fog arithmetic, result register. Uses grc_pkg and grc_div.
module grc_dp #(
  parameter int MAP_SIZE  = grc_pkg::MAP_SIZE_DEF,
  parameter int MAX_STEPS = grc_pkg::MAX_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  grc_pkg::grc_cfg_t   cfg,
  input  grc_pkg::grc_cmd_t   cmd,
  output grc_pkg::grc_sts_t   sts,
  input  logic [4:0]          cell_row,
  input  logic [4:0]          cell_col,
  input  logic [7:0]          cell_value,
  input  logic [8:0]          screen_column,
  output logic [8:0]          column_out,
  output logic [15:0]         wall_distance,
  output logic [7:0]          span_start,
  output logic signed [9:0]   span_end,
  output logic                span_visible,
  output logic                hit_side,
  output logic [7:0]          shade_red,
  output logic [7:0]          shade_green,
  output logic [7:0]          shade_blue
);

  localparam int DEPTH = MAP_SIZE * MAP_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAP_SIZE);
  localparam int SCW   = $clog2(MAX_STEPS + 1);

  logic wall_mem [DEPTH];
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic [AW-1:0] rd_addr;
  logic          rd_wall;

  logic [8:0]         col_r;
  logic [15:0]        ang;
  logic signed [15:0] dx;
  logic signed [15:0] dy;
  logic [14:0]        dx_mag;
  logic [14:0]        dy_mag;
  logic [40:0]        ddx;
  logic [40:0]        ddy;
  logic [47:0]        sdx;
  logic [47:0]        sdy;
  logic [47:0]        perp;
  logic signed [8:0]  mx;
  logic signed [8:0]  my;
  logic signed [8:0]  mx_next;
  logic signed [8:0]  my_next;
  logic               side;
  logic               oob;
  logic               oob_next;
  logic               take_x;
  logic [SCW-1:0]     step_cnt;
  logic [15:0]        perp_dist;
  logic [15:0]        perp_dist_next;

  logic [grc_pkg::DIV_DW-1:0] div_dividend;
  logic [grc_pkg::DIV_VW-1:0] div_divisor;
  logic                       div_done;
  logic [grc_pkg::DIV_DW-1:0] quot;

  logic [11:0] frac_x;
  logic [11:0] frac_y;
  logic [52:0] prod_x;
  logic [52:0] prod_y;

  logic [14:0]        half;
  logic signed [17:0] start_raw;
  logic signed [17:0] end_raw;
  logic signed [17:0] start_cl;
  logic signed [17:0] end_cl;
  logic signed [17:0] vp_bottom;
  logic               visible;
  logic [11:0]        fog;
  logic [7:0]         base_r;
  logic [7:0]         base_g;
  logic [7:0]         base_b;
  logic [19:0]        mix_r;
  logic [19:0]        mix_g;
  logic [19:0]        mix_b;
  logic [19:0]        grey;

  // Map memory: the clearing pass after reset shares the write port.
  assign wr_addr = AW'(cell_row) * AW'(MAP_SIZE) + AW'(cell_col);
  assign wr_en   = cmd.write_cell && (7'(cell_row) < 7'(MAP_SIZE)) &&
                   (7'(cell_col) < 7'(MAP_SIZE));

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      wall_mem[clr_addr] <= 1'b0;
    end else if (wr_en) begin
      wall_mem[wr_addr] <= (cell_value != 8'd0);
    end
    rd_wall <= wall_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Divider operand selection.
  assign dx_mag = dx[15] ? 15'(-dx) : dx[14:0];
  assign dy_mag = dy[15] ? 15'(-dy) : dy[14:0];

  always_comb begin
    unique case (cmd.div_op)
      grc_pkg::DIV_ANGLE: begin
        div_dividend = 32'(cfg.fov) * 32'(screen_column);
        div_divisor  = 16'(cfg.vp_w);
      end
      grc_pkg::DIV_DDX: begin
        div_dividend = 32'h4000_0000;
        div_divisor  = 16'(dx_mag);
      end
      grc_pkg::DIV_DDY: begin
        div_dividend = 32'h4000_0000;
        div_divisor  = 16'(dy_mag);
      end
      default: begin
        div_dividend = {16'd0, cfg.vp_h, 8'd0};
        div_divisor  = perp_dist;
      end
    endcase
  end

  grc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quot)
  );

  // Initial side distances.
  assign frac_x = dx[15] ? {1'b0, cfg.pos_x[10:0]} : 12'd2048 - {1'b0, cfg.pos_x[10:0]};
  assign frac_y = dy[15] ? {1'b0, cfg.pos_y[10:0]} : 12'd2048 - {1'b0, cfg.pos_y[10:0]};
  assign prod_x = 53'(frac_x) * 53'(ddx);
  assign prod_y = 53'(frac_y) * 53'(ddy);

  // One DDA step.
  assign take_x  = sdx < sdy;
  assign mx_next = take_x ? (dx[15] ? mx - 9'sd1 : mx + 9'sd1) : mx;
  assign my_next = take_x ? my : (dy[15] ? my - 9'sd1 : my + 9'sd1);
  assign oob_next = (mx_next < 9'sd0) || (mx_next >= $signed(9'(MAP_SIZE))) ||
                    (my_next < 9'sd0) || (my_next >= $signed(9'(MAP_SIZE)));
  assign rd_addr = oob_next ? '0 :
                   AW'(my_next[CW-1:0]) * AW'(MAP_SIZE) + AW'(mx_next[CW-1:0]);

  assign perp_dist_next = (perp[47:8] == 40'd0) ? 16'd1 :
                          ((perp[47:24] != 24'd0) ? 16'hFFFF : perp[23:8]);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      col_r <= screen_column;
    end
    if (cmd.ang_ld) begin
      ang <= cfg.view_angle - 16'(cfg.fov >> 1) + quot[15:0];
    end
    if (cmd.sine_ld) begin
      dx <= grc_pkg::bin_sine(ang + 16'h4000);
      dy <= grc_pkg::bin_sine(ang);
    end
    if (cmd.ddx_ld) begin
      ddx <= (dx == 16'sd0) ? 41'h100_0000_0000 : 41'(quot[30:0]);
    end
    if (cmd.ddy_ld) begin
      ddy <= (dy == 16'sd0) ? 41'h100_0000_0000 : 41'(quot[30:0]);
    end
    if (cmd.init_ld) begin
      sdx      <= 48'(prod_x >> 11);
      sdy      <= 48'(prod_y >> 11);
      mx       <= $signed({4'd0, cfg.pos_x[15:11]});
      my       <= $signed({4'd0, cfg.pos_y[15:11]});
      perp     <= '0;
      side     <= 1'b0;
      step_cnt <= '0;
    end else if (cmd.step) begin
      if (take_x) begin
        perp <= sdx;
        sdx  <= sdx + 48'(ddx);
      end else begin
        perp <= sdy;
        sdy  <= sdy + 48'(ddy);
      end
      side     <= ~take_x;
      mx       <= mx_next;
      my       <= my_next;
      oob      <= oob_next;
      step_cnt <= step_cnt + 1'b1;
    end
    if (cmd.dist_ld) begin
      perp_dist <= perp_dist_next;
    end
  end

  // Wall span and fog from the line height in the divider.
  assign half      = quot[15:1];
  assign start_raw = 18'(cfg.horizon) - $signed({3'd0, half});
  assign end_raw   = 18'(cfg.horizon) + $signed({3'd0, half});
  assign vp_bottom = $signed({10'd0, cfg.vp_h}) - 18'sd1;
  assign start_cl  = (start_raw < 18'sd0) ? 18'sd0 : start_raw;
  assign end_cl    = (end_raw > vp_bottom) ? vp_bottom : end_raw;
  assign visible   = end_cl >= start_cl;

  assign fog    = (perp_dist > 16'd2048) ? grc_pkg::FOG_LIMIT : perp_dist[11:0];
  assign base_r = side ? grc_pkg::BASE_R_NS : grc_pkg::BASE_R_EW;
  assign base_g = side ? grc_pkg::BASE_G_NS : grc_pkg::BASE_G_EW;
  assign base_b = side ? grc_pkg::BASE_B_NS : grc_pkg::BASE_B_EW;
  assign grey   = 20'(grc_pkg::FOG_GREY) * 20'(fog);
  assign mix_r  = 20'(base_r) * 20'(grc_pkg::FOG_LIMIT - fog) + grey;
  assign mix_g  = 20'(base_g) * 20'(grc_pkg::FOG_LIMIT - fog) + grey;
  assign mix_b  = 20'(base_b) * 20'(grc_pkg::FOG_LIMIT - fog) + grey;

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      column_out    <= col_r;
      wall_distance <= perp_dist;
      hit_side      <= side;
      span_visible  <= visible;
      span_start    <= visible ? start_cl[7:0] : 8'd0;
      span_end      <= visible ? end_cl[9:0] : -10'sd1;
      shade_red     <= visible ? mix_r[18:11] : 8'd0;
      shade_green   <= visible ? mix_g[18:11] : 8'd0;
      shade_blue    <= visible ? mix_b[18:11] : 8'd0;
    end
  end

  assign sts.clear_last = (clr_addr == AW'(DEPTH - 1));
  assign sts.cast_ok    = screen_column < cfg.vp_w;
  assign sts.div_done   = div_done;
  assign sts.walk_stop  = oob || rd_wall || (step_cnt == SCW'(MAX_STEPS));

endmodule

>>> sv/grc_ctrl.sv
// Controller: sequences the clearing pass, map writes and the phases of
// one cast, and owns both handshakes. Uses grc_pkg for its command types.
module grc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  logic              action,
  output logic              res_valid,
  input  logic              res_stall,
  input  grc_pkg::grc_sts_t sts,
  output grc_pkg::grc_cmd_t cmd
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_ANG_DIV  = 4'd2;
  localparam logic [3:0] S_ANG      = 4'd3;
  localparam logic [3:0] S_SINE     = 4'd4;
  localparam logic [3:0] S_DDX_ST   = 4'd5;
  localparam logic [3:0] S_DDX_DIV  = 4'd6;
  localparam logic [3:0] S_DDY_DIV  = 4'd7;
  localparam logic [3:0] S_INIT     = 4'd8;
  localparam logic [3:0] S_STEP     = 4'd9;
  localparam logic [3:0] S_CHECK    = 4'd10;
  localparam logic [3:0] S_DIST     = 4'd11;
  localparam logic [3:0] S_LINE_ST  = 4'd12;
  localparam logic [3:0] S_LINE_DIV = 4'd13;
  localparam logic [3:0] S_FIN      = 4'd14;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       res_free;

  assign cmd_stall = (state != S_IDLE);
  assign res_free  = !res_valid || !res_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          if (action == grc_pkg::ACT_WRITE) begin
            cmd.write_cell = 1'b1;
          end else if (sts.cast_ok) begin
            cmd.load_item = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_op    = grc_pkg::DIV_ANGLE;
            state_next    = S_ANG_DIV;
          end
        end
      end
      S_ANG_DIV: begin
        if (sts.div_done) begin
          state_next = S_ANG;
        end
      end
      S_ANG: begin
        cmd.ang_ld = 1'b1;
        state_next = S_SINE;
      end
      S_SINE: begin
        cmd.sine_ld = 1'b1;
        state_next  = S_DDX_ST;
      end
      S_DDX_ST: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = grc_pkg::DIV_DDX;
        state_next    = S_DDX_DIV;
      end
      S_DDX_DIV: begin
        if (sts.div_done) begin
          cmd.ddx_ld    = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_op    = grc_pkg::DIV_DDY;
          state_next    = S_DDY_DIV;
        end
      end
      S_DDY_DIV: begin
        if (sts.div_done) begin
          cmd.ddy_ld = 1'b1;
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init_ld = 1'b1;
        state_next  = S_STEP;
      end
      S_STEP: begin
        cmd.step   = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = sts.walk_stop ? S_DIST : S_STEP;
      end
      S_DIST: begin
        cmd.dist_ld = 1'b1;
        state_next  = S_LINE_ST;
      end
      S_LINE_ST: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = grc_pkg::DIV_LINE;
        state_next    = S_LINE_DIV;
      end
      S_LINE_DIV: begin
        cmd.div_op = grc_pkg::DIV_LINE;
        if (sts.div_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.div_op = grc_pkg::DIV_LINE;
        if (res_free) begin
          cmd.out_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_ld) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // The clearing pass runs once after reset only.
  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    state != S_CLEAR |=> state != S_CLEAR)
    else $error("clearing pass re-entered");

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_ld |-> (!res_valid || !res_stall))
    else $error("result register overwritten");

  // Starting the divider withdraws its done flag.
  a_div_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !sts.div_done)
    else $error("divider done after start");

  // Every step is followed by its map check.
  a_step_check: assert property (@(posedge clk) disable iff (rst)
    state == S_STEP |=> state == S_CHECK)
    else $error("map check skipped");

endmodule

>>> sv/grid_raycast_column.sv
// Top level of the grid ray-cast column block: register file and the
// controller and datapath. Uses grc_pkg, grc_ctrl and grc_dp.
//
// Use: set the view through the register port, load the wall map with
// write beats (action low), then send cast beats (action high) naming a
// screen column. Each cast below the viewport width gives one result beat
// with distance, wall span, face and shaded colour; write beats and
// casts of columns outside the viewport give none.
// A write beat is taken whenever the block is idle. A cast runs four
// divisions in the shared one-bit-per-cycle divider (column angle, two step
// lengths, line height), walks the grid with a step and then a registered
// map read for each cell, up to MAX_STEPS cells, and has set-up and
// hand-over steps around these. One cast is in work at a time; the input
// is stalled meanwhile.
// After reset a clearing pass writes every map cell open, one per cycle,
// MAP_SIZE * MAP_SIZE cells (1024 by default); the input stays stalled
// through it, and register writes are taken throughout.
// The result sits in an output register. While the receiver stalls, the
// block still takes the next beat and works on it, and holds its finished
// result until the register is free.
module grid_raycast_column #(
  parameter int MAP_SIZE  = grc_pkg::MAP_SIZE_DEF,
  parameter int MAX_STEPS = grc_pkg::MAX_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic               action,
  input  logic [4:0]         cell_row,
  input  logic [4:0]         cell_col,
  input  logic [7:0]         cell_value,
  input  logic [8:0]         screen_column,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [8:0]         column_out,
  output logic [15:0]        wall_distance,
  output logic [7:0]         span_start,
  output logic signed [9:0]  span_end,
  output logic               span_visible,
  output logic               hit_side,
  output logic [7:0]         shade_red,
  output logic [7:0]         shade_green,
  output logic [7:0]         shade_blue
);

  grc_pkg::grc_cfg_t cfg;
  grc_pkg::grc_cmd_t cmd;
  grc_pkg::grc_sts_t sts;
  logic [2:0]        reg_idx;
  logic              reg_we;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign reg_we  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pos_x      <= 16'd0;
      cfg.pos_y      <= 16'd0;
      cfg.view_angle <= 16'd0;
      cfg.fov        <= 15'd10923;
      cfg.vp_w       <= 9'd320;
      cfg.vp_h       <= 8'd240;
      cfg.horizon    <= 10'sd120;
    end else if (reg_we) begin
      unique case (reg_idx)
        grc_pkg::REG_POS_X:   cfg.pos_x      <= pwdata[15:0];
        grc_pkg::REG_POS_Y:   cfg.pos_y      <= pwdata[15:0];
        grc_pkg::REG_VIEW:    cfg.view_angle <= pwdata[15:0];
        grc_pkg::REG_FOV:     cfg.fov        <= pwdata[14:0];
        grc_pkg::REG_VP_W:    cfg.vp_w       <= pwdata[8:0];
        grc_pkg::REG_VP_H:    cfg.vp_h       <= pwdata[7:0];
        grc_pkg::REG_HORIZON: cfg.horizon    <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      grc_pkg::REG_POS_X:   prdata = 32'(cfg.pos_x);
      grc_pkg::REG_POS_Y:   prdata = 32'(cfg.pos_y);
      grc_pkg::REG_VIEW:    prdata = 32'(cfg.view_angle);
      grc_pkg::REG_FOV:     prdata = 32'(cfg.fov);
      grc_pkg::REG_VP_W:    prdata = 32'(cfg.vp_w);
      grc_pkg::REG_VP_H:    prdata = 32'(cfg.vp_h);
      grc_pkg::REG_HORIZON: prdata = {22'd0, cfg.horizon};
      default:              prdata = 32'd0;
    endcase
  end

  grc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .action    (action),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  grc_dp #(
    .MAP_SIZE  (MAP_SIZE),
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .sts           (sts),
    .cell_row      (cell_row),
    .cell_col      (cell_col),
    .cell_value    (cell_value),
    .screen_column (screen_column),
    .column_out    (column_out),
    .wall_distance (wall_distance),
    .span_start    (span_start),
    .span_end      (span_end),
    .span_visible  (span_visible),
    .hit_side      (hit_side),
    .shade_red     (shade_red),
    .shade_green   (shade_green),
    .shade_blue    (shade_blue)
  );

endmodule

>>> tb/grid_raycast_column_test.sv
// Self-checking testbench for grid_raycast_column: directed and random map loads and
// column casts against a behavioural ray caster kept in a scoreboard class.
// Depends on grc_pkg and the grid_raycast_column RTL.
`timescale 1ns / 100ps

module grid_raycast_column_test;

  localparam int MAP_N       = 32;
  localparam int WALK_LIMIT  = 40;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE      = 300;

  typedef struct {
    logic [8:0]  column;
    logic [15:0] distance;
    logic [7:0]  top;
    logic [9:0]  bottom;
    logic        visible;
    logic        side;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } column_shade_t;

  class raycast_scoreboard;
    bit          wall[MAP_N * MAP_N];
    logic [15:0] eye_x = 0;
    logic [15:0] eye_y = 0;
    logic [15:0] heading = 0;
    logic [14:0] fov = 15'd10923;
    logic [8:0]  view_w = 9'd320;
    logic [7:0]  view_h = 8'd240;
    logic [9:0]  horizon = 10'd120;
    int unsigned sine_q14[17] = '{0, 1606, 3196, 4756, 6270, 7723, 9102, 10394, 11585,
                                  12665, 13623, 14449, 15137, 15679, 16069, 16305, 16384};
    column_shade_t pending_q[$];
    int errors = 0;

    function void report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH: %s", msg);
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        grc_pkg::REG_POS_X:   eye_x = value[15:0];
        grc_pkg::REG_POS_Y:   eye_y = value[15:0];
        grc_pkg::REG_VIEW:    heading = value[15:0];
        grc_pkg::REG_FOV:     fov = value[14:0];
        grc_pkg::REG_VP_W:    view_w = value[8:0];
        grc_pkg::REG_VP_H:    view_h = value[7:0];
        grc_pkg::REG_HORIZON: horizon = value[9:0];
        default: ;
      endcase
    endfunction

    function int unsigned quarter_wave(int unsigned u);
      int unsigned i;
      int unsigned f;
      i = u >> 10;
      f = u & 1023;
      if (i >= 16) return sine_q14[16];
      return sine_q14[i] + (((sine_q14[i + 1] - sine_q14[i]) * f) >> 10);
    endfunction

    function int sine_of(logic [15:0] a);
      int unsigned m;
      m = a[14] ? quarter_wave(16384 - int'(a[13:0])) : quarter_wave(int'(a[13:0]));
      return a[15] ? -int'(m) : int'(m);
    endfunction

    // A zero component gets a huge step so that axis never wins the comparison.
    function longint unsigned step_of(int c);
      longint unsigned m;
      m = (c < 0) ? longint'(-c) : longint'(c);
      if (m == 0) return 64'd1 << 40;
      return (64'd1 << 30) / m;
    endfunction

    function void note_beat(logic act, logic [4:0] row, logic [4:0] col_c,
                            logic [7:0] value, logic [8:0] scol);
      logic [31:0] a;
      logic [15:0] ang;
      int dx, dy, mx, my, sx, sy, hor, half, top, bottom;
      longint unsigned ddx, ddy, sdx, sdy, perp, wdist;
      int unsigned line, fog, br, bg, bb, fx, fy;
      bit side;
      column_shade_t e;
      if (act == grc_pkg::ACT_WRITE) begin
        wall[int'(row) * MAP_N + int'(col_c)] = (value != 0);
        return;
      end
      if (scol >= view_w) return;
      a = 32'(heading) - 32'(fov >> 1) + (32'(fov) * 32'(scol)) / 32'(view_w);
      ang = a[15:0];
      dx = sine_of(ang + 16'd16384);
      dy = sine_of(ang);
      ddx = step_of(dx);
      ddy = step_of(dy);
      mx = int'(eye_x >> 11);
      my = int'(eye_y >> 11);
      fx = eye_x & 2047;
      fy = eye_y & 2047;
      if (dx < 0) begin sx = -1; sdx = (longint'(fx) * ddx) >> 11; end
      else begin sx = 1; sdx = (longint'(2048 - fx) * ddx) >> 11; end
      if (dy < 0) begin sy = -1; sdy = (longint'(fy) * ddy) >> 11; end
      else begin sy = 1; sdy = (longint'(2048 - fy) * ddy) >> 11; end
      perp = 0;
      side = 0;
      for (int i = 0; i < WALK_LIMIT; i++) begin
        if (sdx < sdy) begin
          perp = sdx; sdx += ddx; mx += sx; side = 0;
        end else begin
          perp = sdy; sdy += ddy; my += sy; side = 1;
        end
        if (mx < 0 || mx >= MAP_N || my < 0 || my >= MAP_N) break;
        if (wall[my * MAP_N + mx]) break;
      end
      wdist = perp >> 8;
      if (wdist < 1) wdist = 1;
      if (wdist > 65535) wdist = 65535;
      line = int'((longint'(view_h) << 8) / wdist);
      half = int'(line >> 1);
      hor = int'($signed(horizon));
      top = hor - half;
      if (top < 0) top = 0;
      bottom = hor + half;
      if (bottom > int'(view_h) - 1) bottom = int'(view_h) - 1;
      e.column = scol;
      e.distance = wdist[15:0];
      e.side = side;
      if (bottom >= top) begin
        br = side ? 130 : 100;
        bg = side ? 180 : 140;
        bb = side ? 80 : 60;
        fog = (wdist > 2048) ? 2048 : int'(wdist);
        e.top = top[7:0];
        e.bottom = bottom[9:0];
        e.visible = 1;
        e.red = 8'((br * (2048 - fog) + 80 * fog) >> 11);
        e.green = 8'((bg * (2048 - fog) + 80 * fog) >> 11);
        e.blue = 8'((bb * (2048 - fog) + 80 * fog) >> 11);
      end else begin
        e.top = 0;
        e.bottom = 10'h3FF;
        e.visible = 0;
        e.red = 0;
        e.green = 0;
        e.blue = 0;
      end
      pending_q.push_back(e);
    endfunction

    function void check_result(column_shade_t got);
      column_shade_t e;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result beat for column %0d", got.column));
        return;
      end
      e = pending_q.pop_front();
      if (got.column !== e.column)
        report($sformatf("column %0d, expected %0d", got.column, e.column));
      if (got.distance !== e.distance)
        report($sformatf("col %0d distance %0d, expected %0d", e.column, got.distance, e.distance));
      if (got.top !== e.top)
        report($sformatf("col %0d span_start %0d, expected %0d", e.column, got.top, e.top));
      if (got.bottom !== e.bottom)
        report($sformatf("col %0d span_end %h, expected %h", e.column, got.bottom, e.bottom));
      if (got.visible !== e.visible)
        report($sformatf("col %0d span_visible %b, expected %b", e.column, got.visible,
                         e.visible));
      if (got.side !== e.side)
        report($sformatf("col %0d hit_side %b, expected %b", e.column, got.side, e.side));
      if (got.red !== e.red || got.green !== e.green || got.blue !== e.blue)
        report($sformatf("col %0d shade %0d/%0d/%0d, expected %0d/%0d/%0d", e.column,
                         got.red, got.green, got.blue, e.red, e.green, e.blue));
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic psel = 0;
  logic penable = 0;
  logic pwrite = 0;
  logic [4:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;
  logic cmd_valid = 0;
  logic cmd_stall;
  logic action = 0;
  logic [4:0] cell_row = 0;
  logic [4:0] cell_col = 0;
  logic [7:0] cell_value = 0;
  logic [8:0] screen_column = 0;
  logic res_valid;
  logic res_stall = 0;
  logic [8:0] column_out;
  logic [15:0] wall_distance;
  logic [7:0] span_start;
  logic signed [9:0] span_end;
  logic span_visible;
  logic hit_side;
  logic [7:0] shade_red;
  logic [7:0] shade_green;
  logic [7:0] shade_blue;

  raycast_scoreboard sb = new;
  int cycles = 0;
  int stall_left = 0;

  grid_raycast_column dut (.*);

  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: check each accepted beat, then pick the stall for the next cycle.
  always @(posedge clk) begin
    column_shade_t got;
    if (!rst && res_valid && !res_stall) begin
      got.column = column_out;
      got.distance = wall_distance;
      got.top = span_start;
      got.bottom = span_end;
      got.visible = span_visible;
      got.side = hit_side;
      got.red = shade_red;
      got.green = shade_green;
      got.blue = shade_blue;
      sb.check_result(got);
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_stall <= 1;
    end else begin
      res_stall <= 0;
      if ($urandom_range(0, 99) < 25) stall_left <= random_gap();
    end
  end

  // Each access edge is followed at once by the next setup; set_view closes the burst.
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= 5'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
  endtask

  task automatic set_view(logic [15:0] px, logic [15:0] py, logic [15:0] va,
                          logic [14:0] fv, logic [8:0] w, logic [7:0] h, int hz);
    write_reg(grc_pkg::REG_POS_X, 32'(px));
    write_reg(grc_pkg::REG_POS_Y, 32'(py));
    write_reg(grc_pkg::REG_VIEW, 32'(va));
    write_reg(grc_pkg::REG_FOV, 32'(fv));
    write_reg(grc_pkg::REG_VP_W, 32'(w));
    write_reg(grc_pkg::REG_VP_H, 32'(h));
    write_reg(grc_pkg::REG_HORIZON, 32'(hz) & 32'h3FF);
    psel <= 0;
    penable <= 0;
  endtask

  task automatic send_beat(logic act, logic [4:0] row, logic [4:0] col_c,
                           logic [7:0] value, logic [8:0] scol);
    int gap;
    cmd_valid <= 1;
    action <= act;
    cell_row <= row;
    cell_col <= col_c;
    cell_value <= value;
    screen_column <= scol;
    do @(posedge clk); while (cmd_stall);
    sb.note_beat(act, row, col_c, value, scol);
    gap = random_gap();
    if (gap > 0) begin
      cmd_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic cast(logic [8:0] scol);
    send_beat(grc_pkg::ACT_CAST, 5'($urandom), 5'($urandom), 8'($urandom), scol);
  endtask

  task automatic put_cell(int row, int col_c, int value);
    send_beat(grc_pkg::ACT_WRITE, 5'(row), 5'(col_c), 8'(value),
              9'($urandom_range(0, 319)));
  endtask

  // Registers change only once the block has drained.
  task automatic drain();
    cmd_valid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_items(int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 33) begin
        put_cell($urandom_range(0, 31), $urandom_range(0, 31),
                 ($urandom_range(0, 2) == 0) ? $urandom_range(1, 255) : 0);
      end else if (r < 95) begin
        cast(9'($urandom_range(0, sb.view_w - 1)));
      end else begin
        cast(9'($urandom_range(0, 319)));
        n--;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;

    // Directed: viewer in the middle of the map, zero-width view along +x.
    set_view(16'd33792, 16'd33792, 16'd0, 15'd1, 9'd320, 8'd240, 120);
    cast(9'd0);
    put_cell(16, 17, 255);
    cast(9'd319);
    put_cell(0, 0, 1);
    put_cell(31, 31, 200);
    put_cell(16, 17, 0);
    cast(9'd100);
    put_cell(16, 25, 8);
    cast(9'd5);
    drain();
    set_view(16'd34815, 16'd65535, 16'd16384, 15'd32767, 9'd1, 8'd1, -240);
    cast(9'd0);
    cast(9'd1);
    cast(9'd319);
    drain();
    set_view(16'd0, 16'd0, 16'd40000, 15'd16384, 9'd320, 8'd240, 480);
    cast(9'd0);
    cast(9'd319);
    cast(9'd160);
    drain();
    set_view(16'd65535, 16'd0, 16'd49152, 15'd10923, 9'd200, 8'd240, -240);
    cast(9'd199);
    cast(9'd200);
    cast(9'd0);

    // Random phases with a fresh view each time.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: set_view(16'd33000, 16'd30000, 16'd0, 15'd10923, 9'd320, 8'd240, 120);
        1: set_view(16'd0, 16'd65535, 16'($urandom), 15'd32767, 9'd320, 8'd1, 480);
        2: set_view(16'd65535, 16'd65535, 16'($urandom), 15'd1, 9'd1, 8'd240, -240);
        default: set_view(16'($urandom), 16'($urandom), 16'($urandom),
                          15'($urandom_range(1, 32767)), 9'($urandom_range(1, 320)),
                          8'($urandom_range(1, 240)), $urandom_range(0, 720) - 240);
      endcase
      random_items(172);
    end

    drain();
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/grc_pkg.sv
sv/grc_div.sv
sv/grc_dp.sv
sv/grc_ctrl.sv
sv/grid_raycast_column.sv
tb/grid_raycast_column_test.sv
